[hw/rtl/lppd_pkg.sv]
// Package for the length-prefixed packet deframer: header layout constants and result type.
package lppd_pkg;

   localparam int unsigned HEADER_BYTES = 20;
   // Payload lengths stay below 2**31, so the byte position needs 31 bits.
   localparam int unsigned POS_W        = 31;
   localparam int unsigned LEN_END      = 4;
   localparam int unsigned VER_END      = 8;
   localparam int unsigned CMD_END      = 12;

   typedef struct packed {
      logic        length_error;
      logic        end_of_packet;
      logic        byte_present;
      logic [7:0]  payload_byte;
      logic [31:0] command_code;
   } rsp_type;

endpackage

[hw/rtl/length_prefixed_packet_deframer.sv]
// Top level of the length-prefixed packet deframer.
// Takes one stream byte per cycle if ready and splits it into packets, each opening with
// a 20-byte little-endian header: total length (bytes 0..3, header included), version
// (4..7), command (8..11), then ignored bytes. Payload bytes of packets whose version
// equals the csr-written accepted version (reset 1) leave as one result item each, tagged
// with the command, the final one with tlast set; a packet with no payload gives one
// command-only item with tlast. Other versions are consumed without results. A total
// length below 20 (or with bit 31 set) gives one item with the length error flag on the
// last header byte, and the next byte starts a new header. The byte position counter and
// header registers are updated at acceptance and the result goes to an output register, so
// a new item is accepted in every cycle in which the output register is empty or being
// drained.
module length_prefixed_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] command_code, [39:32] payload_byte
   output logic        rsp_tlast,   // end_of_packet
   output logic [1:0]  rsp_tuser,   // [0] byte_present, [1] length_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // accepted_version
);
   import lppd_pkg::*;

   logic             in_payload_ff, in_payload_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      total_length_ff, total_length_in;
   logic [31:0]      version_ff, version_in;
   logic [31:0]      command_ff, command_in;
   logic [31:0]      accepted_version_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             emit;
   logic             req_accept;
   logic [POS_W-1:0] pos_next;
   logic [7:0]       lane_mask;

   function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] lane,
                                            logic [7:0] b);
      logic [31:0] w;
      w = word;
      w[lane*8 +: 8] = b;
      return w;
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign pos_next   = pos_ff + POS_W'(1);
   assign lane_mask  = 8'hFF;

   always_comb begin
      in_payload_in   = in_payload_ff;
      pos_in          = pos_ff;
      total_length_in = total_length_ff;
      version_in      = version_ff;
      command_in      = command_ff;
      emit            = 1'b0;
      rsp_in          = '0;
      if (req_accept) begin
         if (!in_payload_ff) begin
            priority if (pos_ff < POS_W'(LEN_END)) begin
               total_length_in = put_byte(total_length_ff, pos_ff[1:0], req_tdata & lane_mask);
            end else if (pos_ff < POS_W'(VER_END)) begin
               version_in = put_byte(version_ff, pos_ff[1:0], req_tdata);
            end else if (pos_ff < POS_W'(CMD_END)) begin
               command_in = put_byte(command_ff, pos_ff[1:0], req_tdata);
            end else begin
               // padding and ignored data length
            end
            pos_in = pos_next;
            if (pos_ff == POS_W'(HEADER_BYTES - 1)) begin
               priority if (total_length_ff[31] || total_length_ff < 32'(HEADER_BYTES)) begin
                  // drop the header and restart
                  pos_in              = '0;
                  emit                = 1'b1;
                  rsp_in.length_error = 1'b1;
               end else if (total_length_ff == 32'(HEADER_BYTES)) begin
                  pos_in = '0;
                  if (version_ff == accepted_version_ff) begin
                     emit                = 1'b1;
                     rsp_in.command_code = command_ff;
                     rsp_in.end_of_packet = 1'b1;
                  end
               end else begin
                  in_payload_in = 1'b1;
               end
            end
         end else begin
            pos_in = pos_next;
            rsp_in.command_code = command_ff;
            rsp_in.payload_byte = req_tdata;
            rsp_in.byte_present = 1'b1;
            if (pos_next >= total_length_ff[POS_W-1:0]) begin
               rsp_in.end_of_packet = 1'b1;
               in_payload_in        = 1'b0;
               pos_in               = '0;
            end
            emit = (version_ff == accepted_version_ff);
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff       <= 1'b0;
         pos_ff              <= '0;
         total_length_ff     <= '0;
         version_ff          <= '0;
         command_ff          <= '0;
         accepted_version_ff <= 32'd1;
         rsp_valid_ff        <= 1'b0;
      end else begin
         in_payload_ff   <= in_payload_in;
         pos_ff          <= pos_in;
         total_length_ff <= total_length_in;
         version_ff      <= version_in;
         command_ff      <= command_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            accepted_version_ff <= csr_data;
         end
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.payload_byte, rsp_ff.command_code};
   assign rsp_tlast  = rsp_ff.end_of_packet;
   assign rsp_tuser  = {rsp_ff.length_error, rsp_ff.byte_present};

endmodule
